/* rtl/core/scd_pkg.sv */
// Shared constants, codes and types for the serial pin command decoder.
`default_nettype none

package scd_pkg;

  localparam int NumPins     = 14;
  localparam int NumChannels = 8;
  localparam int MaxArgChars = 10;

  localparam logic [3:0] ActSetDir    = 4'd0;
  localparam logic [3:0] ActPull      = 4'd1;
  localparam logic [3:0] ActDigWrite  = 4'd2;
  localparam logic [3:0] ActDigRead   = 4'd3;
  localparam logic [3:0] ActAnaRead   = 4'd4;
  localparam logic [3:0] ActPwmWrite  = 4'd5;
  localparam logic [3:0] ActRefDef    = 4'd6;
  localparam logic [3:0] ActStart     = 4'd7;
  localparam logic [3:0] ActStop      = 4'd8;
  localparam logic [3:0] ActError     = 4'd9;

  localparam logic [3:0] ErrNone       = 4'd0;
  localparam logic [3:0] ErrBadType    = 4'd1;
  localparam logic [3:0] ErrBadOp      = 4'd2;
  localparam logic [3:0] ErrRunaway    = 4'd3;
  localparam logic [3:0] ErrEmptyArg   = 4'd4;
  localparam logic [3:0] ErrPinRange   = 4'd5;
  localparam logic [3:0] ErrBadMode    = 4'd6;
  localparam logic [3:0] ErrPin13Out   = 4'd7;
  localparam logic [3:0] ErrBadPull    = 4'd8;
  localparam logic [3:0] ErrNotInput   = 4'd9;
  localparam logic [3:0] ErrNotOutput  = 4'd10;
  localparam logic [3:0] ErrBadValue   = 4'd11;
  localparam logic [3:0] ErrExtRef     = 4'd12;
  localparam logic [3:0] ErrBadRef     = 4'd13;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  pin;
    logic [7:0]  level;
    logic [3:0]  error_code;
    logic [7:0]  channel_mask;
    logic [31:0] sample_period;
  } scd_result_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } scd_hs_t;

endpackage

`default_nettype wire

/* rtl/core/scd_cmd_if.sv */
// Command byte channel: valid, ready and one received byte.
`default_nettype none

interface scd_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/scd_res_if.sv */
// Result channel: valid, ready and one decoded pin action.
`default_nettype none

interface scd_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [3:0]  pin;
  logic [7:0]  level;
  logic [3:0]  error_code;
  logic [7:0]  channel_mask;
  logic [31:0] sample_period;

  modport source (output valid, output action, output pin, output level,
                  output error_code, output channel_mask, output sample_period,
                  input ready);
  modport sink (input valid, input action, input pin, input level,
                input error_code, input channel_mask, input sample_period,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/scd_in_stage.sv */
// Input register holding one command byte until the parser consumes it.
`default_nettype none

module scd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] byte_i,
  output logic            ready_o,
  input  wire logic       advance_i,
  output logic            vld_o,
  output logic [7:0]      byte_o
);
  import scd_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  scd_hs_t    hs;

  assign hs.valid = valid_i;
  assign hs.ready = !vld_q || advance_i;
  assign ready_o  = hs.ready;

  always_comb begin
    vld_d = vld_q;
    if (advance_i) vld_d = 1'b0;
    if (hs.valid && hs.ready) vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hs.valid && hs.ready) byte_q <= byte_i;
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;
endmodule

`default_nettype wire

/* rtl/core/scd_parser.sv */
// Command parser: phase register, argument accumulators, pin table and checks.
`default_nettype none

module scd_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire logic [7:0]          byte_i,
  output logic                     fire_o,
  output scd_pkg::scd_result_t     res_o
);
  import scd_pkg::*;

  localparam logic [2:0] PH_TYPE = 3'd0;
  localparam logic [2:0] PH_OP   = 3'd1;
  localparam logic [2:0] PH_ARG1 = 3'd2;
  localparam logic [2:0] PH_ARG2 = 3'd3;
  localparam logic [2:0] PH_CHAN = 3'd4;
  localparam logic [2:0] PH_RATE = 3'd5;
  localparam logic [2:0] PH_RUN  = 3'd6;

  localparam logic [1:0] OP_M = 2'd0;
  localparam logic [1:0] OP_P = 2'd1;
  localparam logic [1:0] OP_R = 2'd2;
  localparam logic [1:0] OP_W = 2'd3;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLast  = 8'(32'h61 + NumChannels);

  logic [2:0]         phase_q, phase_d;
  logic               analog_q, analog_d;
  logic [1:0]         op_q, op_d;
  logic [3:0]         chars_q, chars_d;
  logic [31:0]        val_q, val_d;
  logic [31:0]        first_q, first_d;
  logic [7:0]         mask_q, mask_d;
  logic [31:0]        period_q, period_d;
  logic [NumPins-1:0] dir_q, dir_d;

  logic [31:0] byte_ext, val_acc, period_acc;
  logic [31:0] cmd_p, cmd_v;
  logic [3:0]  pidx;
  logic        dir_bit, dig_ok, pwm_pin;
  logic        run_fire, run_we, do_run;
  scd_result_t run_res;
  logic [2:0]  ch_idx;

  function automatic scd_result_t mk_err(logic [3:0] code);
    scd_result_t r;
    r            = '0;
    r.action     = ActError;
    r.error_code = code;
    return r;
  endfunction

  function automatic scd_result_t mk_act(logic [3:0] act, logic [3:0] pn, logic [7:0] lv);
    scd_result_t r;
    r        = '0;
    r.action = act;
    r.pin    = pn;
    r.level  = lv;
    return r;
  endfunction

  assign byte_ext   = {24'd0, byte_i};
  assign val_acc    = (val_q << 3) + (val_q << 1) + byte_ext - 32'(ChZero);
  assign period_acc = (period_q << 3) + (period_q << 1) + byte_ext - 32'(ChZero);
  assign ch_idx     = 3'(byte_i - ChLowA);

  assign cmd_p   = (phase_q == PH_ARG1) ? val_q : first_q;
  assign cmd_v   = (phase_q == PH_ARG1) ? 32'd0 : val_q;
  assign pidx    = cmd_p[3:0];
  assign dir_bit = (pidx < 4'(NumPins)) ? dir_q[pidx] : 1'b0;
  assign dig_ok  = (cmd_p > 32'd1) && (cmd_p < 32'(NumPins));
  assign pwm_pin = (cmd_p == 32'd3) || (cmd_p == 32'd5) || (cmd_p == 32'd6) ||
                   (cmd_p == 32'd9) || (cmd_p == 32'd10) || (cmd_p == 32'd11);

  // Command checks on the completed arguments.
  always_comb begin
    run_fire = 1'b1;
    run_we   = 1'b0;
    run_res  = '0;
    if (!analog_q) begin
      case (op_q)
        OP_M: begin
          if (((cmd_p > 32'd1) && (cmd_p < 32'd13)) ||
              ((cmd_p == 32'd13) && (cmd_v == 32'd0))) begin
            if (cmd_v > 32'd1) begin
              run_res = mk_err(ErrBadMode);
            end else begin
              run_we  = 1'b1;
              run_res = mk_act(ActSetDir, pidx, cmd_v[7:0]);
            end
          end else if ((cmd_p == 32'd13) && (cmd_v == 32'd1)) begin
            run_res = mk_err(ErrPin13Out);
          end else begin
            run_res = mk_err(ErrPinRange);
          end
        end
        OP_P: begin
          if (!dig_ok)             run_res = mk_err(ErrPinRange);
          else if (!dir_bit)       run_res = mk_err(ErrNotInput);
          else if (cmd_v > 32'd1)  run_res = mk_err(ErrBadPull);
          else                     run_res = mk_act(ActPull, pidx, cmd_v[7:0]);
        end
        OP_R: begin
          if (!dig_ok)        run_res = mk_err(ErrPinRange);
          else if (!dir_bit)  run_res = mk_err(ErrNotInput);
          else                run_res = mk_act(ActDigRead, pidx, 8'd0);
        end
        default: begin
          if (!dig_ok)             run_res = mk_err(ErrPinRange);
          else if (dir_bit)        run_res = mk_err(ErrNotOutput);
          else if (cmd_v > 32'd1)  run_res = mk_err(ErrBadValue);
          else                     run_res = mk_act(ActDigWrite, pidx, cmd_v[7:0]);
        end
      endcase
    end else begin
      case (op_q)
        OP_M: begin
          if (cmd_p == 32'd0)       run_res = mk_act(ActRefDef, 4'd0, 8'd0);
          else if (cmd_p == 32'd1)  run_res = mk_err(ErrExtRef);
          else                      run_res = mk_err(ErrBadRef);
        end
        OP_R: begin
          if (cmd_p < 32'(NumChannels)) run_res = mk_act(ActAnaRead, pidx, 8'd0);
          else                          run_res = mk_err(ErrPinRange);
        end
        OP_W: begin
          if (!pwm_pin)              run_res = mk_err(ErrPinRange);
          else if (dir_bit)          run_res = mk_err(ErrNotOutput);
          else if (cmd_v > 32'd255)  run_res = mk_err(ErrBadValue);
          else                       run_res = mk_act(ActPwmWrite, pidx, cmd_v[7:0]);
        end
        default: run_fire = 1'b0;
      endcase
    end
  end

  always_comb begin
    phase_d  = phase_q;
    analog_d = analog_q;
    op_d     = op_q;
    chars_d  = chars_q;
    val_d    = val_q;
    first_d  = first_q;
    mask_d   = mask_q;
    period_d = period_q;
    dir_d    = dir_q;
    fire_o   = 1'b0;
    res_o    = '0;
    do_run   = 1'b0;
    if (advance_i && (byte_i != ChSpace)) begin
      unique case (phase_q)
        PH_TYPE: begin
          chars_d = 4'd0;
          val_d   = 32'd0;
          if (byte_i == ChA) begin
            analog_d = 1'b1;
            phase_d  = PH_OP;
          end else if (byte_i == ChD) begin
            analog_d = 1'b0;
            phase_d  = PH_OP;
          end else if (byte_i == ChR) begin
            phase_d = PH_CHAN;
          end else begin
            fire_o = 1'b1;
            res_o  = mk_err(ErrBadType);
          end
        end
        PH_OP: begin
          phase_d = PH_ARG1;
          case (byte_i)
            ChM: op_d = OP_M;
            ChP: op_d = OP_P;
            ChR: op_d = OP_R;
            ChW: op_d = OP_W;
            default: begin
              phase_d = PH_TYPE;
              fire_o  = 1'b1;
              res_o   = mk_err(ErrBadOp);
            end
          endcase
        end
        PH_ARG1, PH_ARG2: begin
          if (byte_i != ChDot) begin
            if (chars_q >= 4'(MaxArgChars)) begin
              phase_d = PH_TYPE;
              fire_o  = 1'b1;
              res_o   = mk_err(ErrRunaway);
            end else begin
              val_d   = val_acc;
              chars_d = chars_q + 4'd1;
            end
          end else if (chars_q == 4'd0) begin
            phase_d = PH_TYPE;
            fire_o  = 1'b1;
            res_o   = mk_err(ErrEmptyArg);
          end else begin
            chars_d = 4'd0;
            phase_d = PH_TYPE;
            do_run  = 1'b1;
            if (phase_q == PH_ARG1) begin
              first_d = val_q;
              val_d   = 32'd0;
              if (!((analog_q && (op_q == OP_M)) || (op_q == OP_R))) begin
                phase_d = PH_ARG2;
                do_run  = 1'b0;
              end
            end
            if (do_run) begin
              fire_o = run_fire;
              res_o  = run_res;
              if (run_we) dir_d[pidx] = cmd_v[0];
            end
          end
        end
        PH_CHAN: begin
          if ((byte_i >= ChLowA) && (byte_i < ChLast)) begin
            mask_d = mask_q | (8'd1 << ch_idx);
          end else begin
            phase_d = (byte_i == ChDot) ? PH_RATE : PH_TYPE;
          end
        end
        PH_RATE: begin
          if ((byte_i >= ChZero) && (byte_i <= ChNine)) begin
            period_d = period_acc;
          end else if (byte_i == ChDot) begin
            phase_d                  = PH_RUN;
            fire_o                   = 1'b1;
            res_o.action             = ActStart;
            res_o.channel_mask       = mask_q;
            res_o.sample_period      = period_q;
          end else begin
            phase_d = PH_TYPE;
          end
        end
        PH_RUN: begin
          if (byte_i == ChDot) begin
            fire_o              = 1'b1;
            res_o.action        = ActStop;
            res_o.channel_mask  = mask_q;
            res_o.sample_period = period_q;
            mask_d              = 8'd0;
            period_d            = 32'd0;
            phase_d             = PH_TYPE;
          end
        end
        default: phase_d = PH_TYPE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      analog_q <= 1'b0;
      op_q     <= OP_M;
      chars_q  <= 4'd0;
      val_q    <= 32'd0;
      first_q  <= 32'd0;
      mask_q   <= 8'd0;
      period_q <= 32'd0;
      dir_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      analog_q <= analog_d;
      op_q     <= op_d;
      chars_q  <= chars_d;
      val_q    <= val_d;
      first_q  <= first_d;
      mask_q   <= mask_d;
      period_q <= period_d;
      dir_q    <= dir_d;
    end
  end
endmodule

`default_nettype wire

/* rtl/core/scd_out_stage.sv */
// Result register holding one decoded action until the sink takes it.
`default_nettype none

module scd_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire scd_pkg::scd_result_t res_i,
  input  wire logic                 ready_i,
  output logic                      valid_o,
  output scd_pkg::scd_result_t      res_o
);
  import scd_pkg::*;

  logic        vld_q, vld_d;
  scd_result_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (ready_i) vld_d = 1'b0;
    if (load_i)  vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;
endmodule

`default_nettype wire

/* rtl/core/serial_pin_command_decoder.sv */
// Top level of the serial pin command decoder.
//
//  channel  dir  payload                                       transaction
//  cmd_i    in   rx_byte[7:0]                                  one command byte
//  res_o    out  action, pin, level, error_code,               zero or one per byte
//                channel_mask, sample_period
//
// One byte per cycle sustained while the result sink does not stall.
// Byte register, then parser logic, then result register; the parser consumes a byte
// whenever the result register is empty or being emptied in the same cycle.
// A stalled result sink holds the parser; one more byte waits in the byte register.
// Reset clears the parse phase, accumulators, sampling setup and all pins to output.
`default_nettype none

module serial_pin_command_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scd_cmd_if.sink   cmd_i,
  scd_res_if.source res_o
);
  import scd_pkg::*;

  logic        in_vld, advance, fire;
  logic [7:0]  in_byte;
  scd_result_t pres, ores;
  scd_hs_t     out_hs;

  assign out_hs.valid = res_o.valid;
  assign out_hs.ready = res_o.ready;
  assign advance      = in_vld && (!out_hs.valid || out_hs.ready);

  scd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (cmd_i.valid),
    .byte_i    (cmd_i.rx_byte),
    .ready_o   (cmd_i.ready),
    .advance_i (advance),
    .vld_o     (in_vld),
    .byte_o    (in_byte)
  );

  scd_parser u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte),
    .fire_o    (fire),
    .res_o     (pres)
  );

  scd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (pres),
    .ready_i (res_o.ready),
    .valid_o (res_o.valid),
    .res_o   (ores)
  );

  assign res_o.action        = ores.action;
  assign res_o.pin           = ores.pin;
  assign res_o.level         = ores.level;
  assign res_o.error_code    = ores.error_code;
  assign res_o.channel_mask  = ores.channel_mask;
  assign res_o.sample_period = ores.sample_period;

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.action == ActError) == (res_o.error_code != ErrNone)))
    else $error("error code disagrees with action");

  a_fire_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> advance)
    else $error("result produced without consuming a byte");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !fire)
    else $error("result overwrites a pending result");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> (in_vld && res_o.valid && !res_o.ready))
    else $error("byte input stalled without a full pipeline");

  a_sample_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && ((res_o.action == ActStart) || (res_o.action == ActStop)))
      |-> ((res_o.pin == 4'd0) && (res_o.level == 8'd0)))
    else $error("sampling action carries a pin or level");
endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the serial pin command decoder, driven by directed commands and random byte streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scd_pkg::*;

  localparam logic [7:0] ChSpace = " ";
  localparam logic [7:0] ChDot   = ".";
  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChNine  = "9";
  localparam logic [7:0] ChA     = "A";
  localparam logic [7:0] ChD     = "D";
  localparam logic [7:0] ChR     = "R";
  localparam logic [7:0] ChM     = "M";
  localparam logic [7:0] ChP     = "P";
  localparam logic [7:0] ChW     = "W";
  localparam logic [7:0] ChLowA  = "a";

  localparam int RandomItems = 330;
  localparam int PhaseItems  = 66;
  localparam int HoldCycles  = 300;

  typedef enum logic [2:0] {
    PhType, PhOp, PhArg1, PhArg2, PhChan, PhRate, PhRun
  } parse_phase_e;

  typedef enum logic [1:0] {OpMode, OpPull, OpRead, OpWrite} op_kind_e;

  class pin_action_board;
    parse_phase_e phase;
    bit           analog;
    op_kind_e     op;
    int unsigned  nchars;
    logic [31:0]  acc;
    logic [31:0]  first;
    bit           pin_in[NumPins];
    logic [7:0]   mask;
    logic [31:0]  period;
    scd_result_t  expected_actions[$];
    int unsigned  mismatches;

    function new();
      phase  = PhType;
      analog = 1'b0;
      op     = OpMode;
      nchars = 0;
      acc    = '0;
      first  = '0;
      foreach (pin_in[i]) pin_in[i] = 1'b0;
      mask   = '0;
      period = '0;
      mismatches = 0;
    endfunction

    function void note_result(logic [3:0] act, logic [31:0] p, logic [31:0] v,
                              logic [3:0] err, logic [7:0] msk, logic [31:0] per);
      scd_result_t r;
      r.action        = act;
      r.pin           = p[3:0];
      r.level         = v[7:0];
      r.error_code    = err;
      r.channel_mask  = msk;
      r.sample_period = per;
      expected_actions.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [31:0] p;
      logic [31:0] v;
      bit          dig_ok;
      if (b == ChSpace) return;
      case (phase)
        PhType: begin
          nchars = 0;
          acc    = '0;
          if (b == ChA) begin
            analog = 1'b1;
            phase  = PhOp;
          end else if (b == ChD) begin
            analog = 1'b0;
            phase  = PhOp;
          end else if (b == ChR) begin
            phase = PhChan;
          end else begin
            note_result(ActError, 0, 0, ErrBadType, 0, 0);
          end
        end
        PhOp: begin
          phase = PhArg1;
          case (b)
            ChM: op = OpMode;
            ChP: op = OpPull;
            ChR: op = OpRead;
            ChW: op = OpWrite;
            default: begin
              phase = PhType;
              note_result(ActError, 0, 0, ErrBadOp, 0, 0);
            end
          endcase
        end
        PhArg1, PhArg2: begin
          if (b != ChDot) begin
            if (nchars >= MaxArgChars) begin
              phase = PhType;
              note_result(ActError, 0, 0, ErrRunaway, 0, 0);
            end else begin
              acc = acc * 32'd10 + ({24'd0, b} - {24'd0, ChZero});
              nchars++;
            end
            return;
          end
          if (nchars == 0) begin
            phase = PhType;
            note_result(ActError, 0, 0, ErrEmptyArg, 0, 0);
            return;
          end
          nchars = 0;
          if (phase == PhArg1) begin
            first = acc;
            acc   = '0;
            if (!((analog && op == OpMode) || op == OpRead)) begin
              phase = PhArg2;
              return;
            end
          end
          phase  = PhType;
          p      = first;
          v      = acc;
          dig_ok = (p > 1) && (p < NumPins);
          if (!analog) begin
            case (op)
              OpMode: begin
                if ((p > 1 && p < 13) || (p == 13 && v == 0)) begin
                  if (v > 1) begin
                    note_result(ActError, 0, 0, ErrBadMode, 0, 0);
                  end else begin
                    pin_in[p] = v[0];
                    note_result(ActSetDir, p, v, ErrNone, 0, 0);
                  end
                end else if (p == 13 && v == 1) begin
                  note_result(ActError, 0, 0, ErrPin13Out, 0, 0);
                end else begin
                  note_result(ActError, 0, 0, ErrPinRange, 0, 0);
                end
              end
              OpPull: begin
                if (!dig_ok) note_result(ActError, 0, 0, ErrPinRange, 0, 0);
                else if (!pin_in[p]) note_result(ActError, 0, 0, ErrNotInput, 0, 0);
                else if (v > 1) note_result(ActError, 0, 0, ErrBadPull, 0, 0);
                else note_result(ActPull, p, v, ErrNone, 0, 0);
              end
              OpRead: begin
                if (!dig_ok) note_result(ActError, 0, 0, ErrPinRange, 0, 0);
                else if (!pin_in[p]) note_result(ActError, 0, 0, ErrNotInput, 0, 0);
                else note_result(ActDigRead, p, 0, ErrNone, 0, 0);
              end
              default: begin
                if (!dig_ok) note_result(ActError, 0, 0, ErrPinRange, 0, 0);
                else if (pin_in[p]) note_result(ActError, 0, 0, ErrNotOutput, 0, 0);
                else if (v > 1) note_result(ActError, 0, 0, ErrBadValue, 0, 0);
                else note_result(ActDigWrite, p, v, ErrNone, 0, 0);
              end
            endcase
          end else begin
            case (op)
              OpMode: begin
                if (p == 0) note_result(ActRefDef, 0, 0, ErrNone, 0, 0);
                else if (p == 1) note_result(ActError, 0, 0, ErrExtRef, 0, 0);
                else note_result(ActError, 0, 0, ErrBadRef, 0, 0);
              end
              OpRead: begin
                if (p < NumChannels) note_result(ActAnaRead, p, 0, ErrNone, 0, 0);
                else note_result(ActError, 0, 0, ErrPinRange, 0, 0);
              end
              OpWrite: begin
                if (!(p == 3 || p == 5 || p == 6 || p == 9 || p == 10 || p == 11))
                  note_result(ActError, 0, 0, ErrPinRange, 0, 0);
                else if (pin_in[p]) note_result(ActError, 0, 0, ErrNotOutput, 0, 0);
                else if (v > 255) note_result(ActError, 0, 0, ErrBadValue, 0, 0);
                else note_result(ActPwmWrite, p, v, ErrNone, 0, 0);
              end
              default: ;
            endcase
          end
        end
        PhChan: begin
          if (b >= ChLowA && b < ChLowA + NumChannels) begin
            mask = mask | (8'd1 << (b - ChLowA));
          end else begin
            phase = (b == ChDot) ? PhRate : PhType;
          end
        end
        PhRate: begin
          if (b >= ChZero && b <= ChNine) begin
            period = period * 32'd10 + {24'd0, b - ChZero};
          end else if (b == ChDot) begin
            phase = PhRun;
            note_result(ActStart, 0, 0, ErrNone, mask, period);
          end else begin
            phase = PhType;
          end
        end
        PhRun: begin
          if (b == ChDot) begin
            note_result(ActStop, 0, 0, ErrNone, mask, period);
            mask   = '0;
            period = '0;
            phase  = PhType;
          end
        end
        default: phase = PhType;
      endcase
    endfunction

    function void check_action(scd_result_t got);
      scd_result_t want;
      if (expected_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result act %0d pin %0d lvl %0d err %0d mask %h per %0d",
                   got.action, got.pin, got.level, got.error_code, got.channel_mask,
                   got.sample_period);
        return;
      end
      want = expected_actions.pop_front();
      if (got.action !== want.action || got.pin !== want.pin || got.level !== want.level ||
          got.error_code !== want.error_code || got.channel_mask !== want.channel_mask ||
          got.sample_period !== want.sample_period) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: mismatch expected act %0d pin %0d lvl %0d err %0d mask %h per %0d",
                   want.action, want.pin, want.level, want.error_code, want.channel_mask,
                   want.sample_period);
          $display("tb:          actual   act %0d pin %0d lvl %0d err %0d mask %h per %0d",
                   got.action, got.pin, got.level, got.error_code, got.channel_mask,
                   got.sample_period);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  scd_cmd_if cmd ();
  scd_res_if res ();

  serial_pin_command_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd.sink),
    .res_o  (res.source)
  );

  pin_action_board sb = new();

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned items_sent = 0;
  bit          hold_req   = 1'b0;
  logic [7:0]  burst[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      cmd.valid   <= 1'b0;
      cmd.rx_byte <= 8'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    cmd.valid   <= 1'b1;
    cmd.rx_byte <= b;
    do @(posedge clk_i); while (!cmd.ready);
    sb.take_byte(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_actions();
    cmd.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_actions.size() != 0);
  endtask

  function automatic void add_byte(logic [7:0] b);
    if ($urandom_range(19) == 0) burst.push_back(ChSpace);
    burst.push_back(b);
  endfunction

  function automatic void add_dec(logic [31:0] n);
    logic [7:0] digits[$];
    if ($urandom_range(9) == 0) digits.push_back(ChZero);
    do begin
      digits.push_front(ChZero + 8'(n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (digits[i]) add_byte(digits[i]);
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(300);
      2: return $urandom_range(2);
      default: return $urandom_range(15);
    endcase
  endfunction

  function automatic void fill_command();
    int unsigned r;
    int unsigned n;
    logic [7:0]  op_letter;
    logic [7:0]  junk;
    r = $urandom_range(99);
    if (r < 60) begin
      case ($urandom_range(3))
        0: op_letter = ChM;
        1: op_letter = ChP;
        2: op_letter = ChR;
        default: op_letter = ChW;
      endcase
      add_byte($urandom_range(1) ? ChA : ChD);
      add_byte(op_letter);
      add_dec(pick_arg());
      add_byte(ChDot);
      if (op_letter != ChR && !(burst[0] == ChA && op_letter == ChM) &&
          !(burst.size() > 1 && burst[1] == ChA && op_letter == ChM)) begin
        add_dec($urandom_range(1) ? 32'($urandom_range(1)) : pick_arg());
        add_byte(ChDot);
      end
    end else if (r < 75) begin
      add_byte(ChR);
      n = $urandom_range(4);
      repeat (n) add_byte(ChLowA + 8'($urandom_range(NumChannels - 1)));
      if ($urandom_range(9) == 0) add_byte(ChLowA + 8'($urandom_range(25)));
      add_byte(ChDot);
      n = $urandom_range(6);
      repeat (n) add_byte(ChZero + 8'($urandom_range(9)));
      if ($urandom_range(19) == 0) add_byte(ChA);
      add_byte(ChDot);
      n = $urandom_range(4);
      repeat (n) begin
        do junk = 8'($urandom); while (junk == ChDot);
        add_byte(junk);
      end
      add_byte(ChDot);
    end else if (r < 85) begin
      add_byte(ChD);
      case ($urandom_range(3))
        0: begin
          add_byte(ChM);
          add_byte(ChDot);
        end
        1: begin
          add_byte(ChW);
          n = $urandom_range(11, 13);
          repeat (n) add_byte(ChZero + 8'($urandom_range(9)));
        end
        2: begin
          add_byte(ChP);
          add_dec($urandom_range(15));
        end
        default: add_byte(8'($urandom));
      endcase
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) add_byte(8'($urandom));
    end
  endfunction

  initial begin
    scd_result_t got;
    int unsigned hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) begin
        got.action        = res.action;
        got.pin           = res.pin;
        got.level         = res.level;
        got.error_code    = res.error_code;
        got.channel_mask  = res.channel_mask;
        got.sample_period = res.sample_period;
        sb.check_action(got);
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    string       dir_cmds[];
    int unsigned idle_tab[5];
    int unsigned stall_tab[5];
    int unsigned start_count;
    int unsigned k;
    int unsigned k_prev;
    idle_tab  = '{0, 79, 0, 35, 0};
    stall_tab = '{0, 0, 79, 35, 0};
    dir_cmds  = '{"DM2.1.", "DP2.1.", "DP2.2.", "DR2.", "DW2.1.", "DM2.0.", "DW2.1.",
                  "DW2.2.", "DM13.0.", "DM13.1.", "DM1.0.", "DM5.2.", "DR13.", "DM9.1.",
                  "AW9.7.", "AM0.", "AM1.", "AM2.", "AR7.", "AR8.", "AW3.255.",
                  "AW11.256.", "AW4.1.", "AP3.1.", "X", "DQ", "DM12345678901", "DM.",
                  " D M 9 . 0 . ", "DM4294967295.0.", "DW3Z.1.", "Rabh.100.xy.", "Rai",
                  "Rb.5..", "Rc.12Z", "R.3.."};
    cmd.valid   <= 1'b0;
    cmd.rx_byte <= '0;
    rst_ni      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    foreach (dir_cmds[i]) send_text(dir_cmds[i]);
    drain_actions();

    hold_req    = 1'b1;
    start_count = items_sent;
    k_prev      = 0;
    while (items_sent - start_count < RandomItems) begin
      k = ((items_sent - start_count) / PhaseItems) % 5;
      if (k != k_prev) begin
        k_prev = k;
        if (k == 3) drain_actions();
        idle_pct  = idle_tab[k];
        stall_pct = stall_tab[k];
      end
      fill_command();
      foreach (burst[i]) send_byte(burst[i]);
      burst.delete();
    end

    stall_pct = 0;
    drain_actions();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_actions.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
